// ===== hw/rtl/clrf_pkg.sv =====
// Shared types, codes and widths for the clipped rectangle fill engine.
// No dependencies; every other file takes names from here by scope.
package clrf_pkg;

  localparam int COORD_W = 10;
  localparam int VALUE_W = 8;
  localparam int FRAME_W = 9;
  localparam int COL_W = 8;
  localparam int ROW_W = 8;
  localparam int SIZE_W = 9;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd256;

  // Input opcodes.
  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes (paddr bit 2).
  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Command kinds passed from the front to the back.
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_FILL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ZERO = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   kind;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] xend;
    logic [COORD_W-1:0] yend;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ===== hw/rtl/clrf_front.sv =====
// Front end: accepts input transfers, clips them against the frame and
// classifies them into commands. Depends on clrf_pkg.
module clrf_front #(
  parameter int MAX_WIDTH = clrf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = clrf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [clrf_pkg::COL_W-1:0]    start_column,
  input  logic [clrf_pkg::ROW_W-1:0]    start_row,
  input  logic [clrf_pkg::SIZE_W-1:0]   rect_width,
  input  logic [clrf_pkg::SIZE_W-1:0]   rect_height,
  input  logic [clrf_pkg::VALUE_W-1:0]  fill_value,
  input  logic [clrf_pkg::FRAME_W-1:0]  frame_width,
  input  logic [clrf_pkg::FRAME_W-1:0]  frame_height,
  input  clrf_pkg::queue_status_t       qs,
  input  clrf_pkg::back_status_t        bs,
  output logic                          push,
  output clrf_pkg::cmd_t                cmd
);

  logic [clrf_pkg::COORD_W-1:0] xlim, ylim, col, row, xend, yend, xsum, ysum;
  logic drop;

  assign col = clrf_pkg::COORD_W'(start_column);
  assign row = clrf_pkg::COORD_W'(start_row);

  always_comb begin
    // The clip limits taken from the frame registers saturate at the store size.
    if (32'(frame_width) > MAX_WIDTH) xlim = clrf_pkg::COORD_W'(MAX_WIDTH);
    else xlim = clrf_pkg::COORD_W'(frame_width);
    if (32'(frame_height) > MAX_HEIGHT) ylim = clrf_pkg::COORD_W'(MAX_HEIGHT);
    else ylim = clrf_pkg::COORD_W'(frame_height);

    xsum = col + clrf_pkg::COORD_W'(rect_width);
    ysum = row + clrf_pkg::COORD_W'(rect_height);
    xend = (xsum > xlim) ? xlim : xsum;
    yend = (ysum > ylim) ? ylim : ysum;

    drop = 1'b0;
    cmd.x0 = col;
    cmd.y0 = row;
    cmd.xend = xend;
    cmd.yend = yend;
    cmd.value = fill_value;
    if (opcode == clrf_pkg::OP_READ) begin
      if (col < xlim && row < ylim) cmd.kind = clrf_pkg::CMD_READ;
      else cmd.kind = clrf_pkg::CMD_ZERO;
    end else begin
      cmd.kind = clrf_pkg::CMD_FILL;
      // A fill that covers no pixel inside the frame leaves nothing to do.
      drop = !(col < xend && row < yend);
    end
  end

  assign in_stall = qs.full || bs.clearing;
  assign push = in_valid && !in_stall && !drop;

endmodule

// ===== hw/rtl/clrf_queue.sv =====
// Short command queue between the front and the back end.
// Depends on clrf_pkg.
module clrf_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  clrf_pkg::cmd_t          cmd,
  input  logic                    pop,
  output clrf_pkg::cmd_t          head,
  output clrf_pkg::queue_status_t qs
);

  clrf_pkg::cmd_t slots [clrf_pkg::QUEUE_DEPTH];
  logic [clrf_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [clrf_pkg::QPTR_W:0] count;

  assign head = slots[rd_ptr];
  assign qs.empty = (count == '0);
  assign qs.full = (count == (clrf_pkg::QPTR_W + 1)'(clrf_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/clrf_back.sv =====
// Back end: clears the frame store after reset, then runs fills one pixel
// per cycle and reads through the registered store port. Depends on clrf_pkg.
module clrf_back #(
  parameter int MAX_WIDTH = clrf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = clrf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  clrf_pkg::cmd_t               head,
  input  clrf_pkg::queue_status_t      qs,
  output logic                         pop,
  output clrf_pkg::back_status_t       bs,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [clrf_pkg::VALUE_W-1:0] pixel_value
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int DEPTH = 2 ** AW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_RDWAIT = 2'd3;

  logic [clrf_pkg::VALUE_W-1:0] store [DEPTH];
  logic [clrf_pkg::VALUE_W-1:0] rdata, wdata, out_next, value;
  logic [AW-1:0] clr_addr, waddr, raddr;
  logic [1:0] state, state_next;
  logic [clrf_pkg::COORD_W-1:0] x, y, x0, xend, yend;
  logic we, re, out_load, out_free, x_last, y_last;

  // Row-major address with the row in the upper bits.
  function automatic logic [AW-1:0] pix_addr(input logic [clrf_pkg::COORD_W-1:0] px,
                                             input logic [clrf_pkg::COORD_W-1:0] py);
    return (AW'(py) << CW) | AW'(px);
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign x_last = (x + clrf_pkg::COORD_W'(1)) == xend;
  assign y_last = (y + clrf_pkg::COORD_W'(1)) == yend;
  assign bs.clearing = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    pop = 1'b0;
    we = 1'b0;
    waddr = pix_addr(x, y);
    wdata = value;
    re = 1'b0;
    raddr = pix_addr(head.x0, head.y0);
    out_load = 1'b0;
    out_next = rdata;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (&clr_addr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (!qs.empty) begin
          case (head.kind)
            clrf_pkg::CMD_FILL: begin
              pop = 1'b1;
              state_next = ST_FILL;
            end
            clrf_pkg::CMD_READ: begin
              pop = 1'b1;
              re = 1'b1;
              state_next = ST_RDWAIT;
            end
            clrf_pkg::CMD_ZERO: begin
              if (out_free) begin
                pop = 1'b1;
                out_load = 1'b1;
                out_next = '0;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (x_last && y_last) state_next = ST_IDLE;
      end
      ST_RDWAIT: begin
        // The read data register holds until the result register is free.
        if (out_free) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
    if (re) rdata <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) pixel_value <= out_next;
    if (state == ST_IDLE && pop && head.kind == clrf_pkg::CMD_FILL) begin
      x <= head.x0;
      y <= head.y0;
      x0 <= head.x0;
      xend <= head.xend;
      yend <= head.yend;
      value <= head.value;
    end else if (state == ST_FILL) begin
      if (x_last) begin
        x <= x0;
        y <= y + clrf_pkg::COORD_W'(1);
      end else begin
        x <= x + clrf_pkg::COORD_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/clipped_rectangle_fill.sv =====
// Top level of the clipped rectangle fill engine: frame registers, APB port,
// and the front end, command queue and back end. Depends on clrf_pkg.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  opcode, start_column, start_row,
//                                            rect_width, rect_height, fill_value
//  out       output     out_valid/out_stall  pixel_value
//  cfg       input      psel/penable/pready  paddr, pwdata, prdata
//
// A fill occupies the back end for a setup step in the idle state, then writes
// each clipped pixel in turn through the single store write port. A read goes
// through the registered store read port into the result register; a read
// outside the frame loads a zero result without a store access. Fills that cover
// no pixel cost no back end time. After reset the store is swept to zero, all
// 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) words (65536 at defaults), in_stall high.
// The queue lets input transfers continue while a result waits on out_stall.
module clipped_rectangle_fill #(
  parameter int MAX_WIDTH = clrf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = clrf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [clrf_pkg::COL_W-1:0]   start_column,
  input  logic [clrf_pkg::ROW_W-1:0]   start_row,
  input  logic [clrf_pkg::SIZE_W-1:0]  rect_width,
  input  logic [clrf_pkg::SIZE_W-1:0]  rect_height,
  input  logic [clrf_pkg::VALUE_W-1:0] fill_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [clrf_pkg::VALUE_W-1:0] pixel_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [clrf_pkg::FRAME_W-1:0] frame_width, frame_height;
  logic push, pop, cfg_write;
  clrf_pkg::cmd_t cmd, head;
  clrf_pkg::queue_status_t qs;
  clrf_pkg::back_status_t bs;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == clrf_pkg::REG_FRAME_HEIGHT) ?
                  32'(frame_height) : 32'(frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= clrf_pkg::FRAME_RESET;
      frame_height <= clrf_pkg::FRAME_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == clrf_pkg::REG_FRAME_WIDTH) frame_width <= pwdata[clrf_pkg::FRAME_W-1:0];
      else frame_height <= pwdata[clrf_pkg::FRAME_W-1:0];
    end
  end

  clrf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .start_column(start_column), .start_row(start_row),
    .rect_width(rect_width), .rect_height(rect_height), .fill_value(fill_value),
    .frame_width(frame_width), .frame_height(frame_height),
    .qs(qs), .bs(bs), .push(push), .cmd(cmd)
  );

  clrf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .cmd(cmd), .pop(pop), .head(head), .qs(qs)
  );

  clrf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk(clk), .rst(rst), .head(head), .qs(qs), .pop(pop), .bs(bs),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_value(pixel_value)
  );

  // No input transfer may land while the store is being swept.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    bs.clearing |-> in_stall)
    else $error("input accepted during clearing pass");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qs.full && qs.empty))
    else $error("queue full and empty at once");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qs.empty)
    else $error("queue popped while empty");

  a_no_result_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(bs.clearing))
    else $error("result produced during clearing pass");

endmodule
